// ===== src/cs_pkg.sv =====
// Shared types, constants and helpers of the comb sorter.
// Used by every module of the block but cs_ram; depends on nothing.
package cs_pkg;

  // Fixed port field widths
  localparam int unsigned KEY_BITS      = 32;
  localparam int unsigned KEY_WIDE_BITS = 64;

  // Defaults of the top-level parameters
  localparam int unsigned DEF_MAX_KEYS  = 64;
  localparam int unsigned DEF_KEY_WIDTH = 32;

  // Gap shrink: floor(v*10/13) as (v * 6310) >> 13, exact for v*10 < 744
  localparam int unsigned SHRINK_IN_BITS   = 7;
  localparam int unsigned SHRINK_PROD_BITS = 20;
  localparam int unsigned SHRINK_SHIFT     = 13;
  localparam logic [SHRINK_PROD_BITS-1:0] SHRINK_MUL = 20'd6310;

  // Input item
  typedef struct packed {
    logic [KEY_BITS-1:0] key;
    logic                is_last;
  } key_in_t;

  // Result item
  typedef struct packed {
    logic [KEY_BITS-1:0] sorted_key;
    logic                end_of_set;
  } key_out_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic sort_init;
    logic rd_pair;
    logic wr_first;
    logic wr_second;
    logic step;
    logic emit_rd;
    logic clear;
  } cs_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic single;
    logic pass_last;
    logic sort_done;
    logic do_swap;
    logic emit_last;
  } cs_status_t;

  // Next comb sort gap, floor(v*10/13)
  function automatic logic [SHRINK_IN_BITS-1:0] shrink(input logic [SHRINK_IN_BITS-1:0] v);
    logic [SHRINK_PROD_BITS-1:0] prod;
    prod = SHRINK_PROD_BITS'(v) * SHRINK_MUL;
    return prod[SHRINK_SHIFT +: SHRINK_IN_BITS];
  endfunction

endpackage

// ===== src/comb_sorter_top.sv =====
// Comb sorter: collects keys (one per cycle while idle) until a key marked last, then
// sorts them ascending with comb sort (gap shrink 10/13) and emits them one per cycle.
// Each compare reads a pair, compares it and, on a swap, writes the two keys back one
// after the other, through the single store with two read ports and one write port.
// Results cannot be stalled. Reset clears count, gap and flags; store contents are
// undefined until loaded.
module comb_sorter_top #(
  parameter int unsigned MAX_KEYS  = cs_pkg::DEF_MAX_KEYS,
  parameter int unsigned KEY_WIDTH = cs_pkg::DEF_KEY_WIDTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  cs_pkg::key_in_t  key_i,
  output cs_pkg::key_out_t res_o,
  output logic             res_strobe_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic             cfg_data_i
);

  cs_pkg::cs_cmd_t    cmd;
  cs_pkg::cs_status_t status;

  // Config register always takes a transfer
  assign cfg_ready_o = 1'b1;

  cs_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .is_last_i(key_i.is_last),
    .status_i (status),
    .cmd_o    (cmd),
    .busy     (busy)
  );

  cs_datapath #(
    .MAX_KEYS (MAX_KEYS),
    .KEY_WIDTH(KEY_WIDTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .key_i       (key_i.key),
    .cmd_i       (cmd),
    .status_o    (status),
    .res_o       (res_o),
    .res_strobe_o(res_strobe_o)
  );

endmodule

// ===== src/cs_ram.sv =====
// Generic RAM: one write port, two read ports with registered, enabled read.
// Standalone; no package use.
module cs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic                     re_b_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read ports, hold data while not enabled
  always_ff @(posedge clk_i) begin
    if (re_a_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
    end
    if (re_b_i) begin
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

// ===== src/cs_ctrl.sv =====
// Controller of the comb sorter: load, sort pass sequencing and emit.
// Depends on cs_pkg for command and status types.
module cs_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  input  logic               is_last_i,
  input  cs_pkg::cs_status_t status_i,
  output cs_pkg::cs_cmd_t    cmd_o,
  output logic               busy
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_START = 3'd1;
  localparam logic [2:0] S_RD    = 3'd2;
  localparam logic [2:0] S_CMP   = 3'd3;
  localparam logic [2:0] S_WR2   = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;
  localparam logic [2:0] S_DRAIN = 3'd6;

  logic [2:0] state_q;
  logic [2:0] state_d;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          if (is_last_i) begin
            state_d = S_START;
          end
        end
      end
      S_START: begin
        if (status_i.single) begin
          state_d = S_EMIT;
        end else begin
          cmd_o.sort_init = 1'b1;
          state_d         = S_RD;
        end
      end
      S_RD: begin
        cmd_o.rd_pair = 1'b1;
        state_d       = S_CMP;
      end
      S_CMP: begin
        if (status_i.do_swap) begin
          cmd_o.wr_first = 1'b1;
          state_d        = S_WR2;
        end else begin
          cmd_o.step = 1'b1;
          state_d    = (status_i.pass_last && status_i.sort_done) ? S_EMIT : S_RD;
        end
      end
      S_WR2: begin
        cmd_o.wr_second = 1'b1;
        cmd_o.step      = 1'b1;
        state_d         = (status_i.pass_last && status_i.sort_done) ? S_EMIT : S_RD;
      end
      S_EMIT: begin
        cmd_o.emit_rd = 1'b1;
        if (status_i.emit_last) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        cmd_o.clear = 1'b1;
        state_d     = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != S_IDLE);

endmodule

// ===== src/cs_datapath.sv =====
// Datapath of the comb sorter: key store, count, gap, pass index, compare.
// Depends on cs_pkg and instantiates cs_ram.
module cs_datapath #(
  parameter int unsigned MAX_KEYS  = cs_pkg::DEF_MAX_KEYS,
  parameter int unsigned KEY_WIDTH = cs_pkg::DEF_KEY_WIDTH
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic                        cfg_data_i,
  input  logic [cs_pkg::KEY_BITS-1:0] key_i,
  input  cs_pkg::cs_cmd_t             cmd_i,
  output cs_pkg::cs_status_t          status_o,
  output cs_pkg::key_out_t            res_o,
  output logic                        res_strobe_o
);

  localparam int unsigned AW = $clog2(MAX_KEYS);
  localparam int unsigned CW = $clog2(MAX_KEYS + 1);
  localparam int unsigned GW = AW;

  logic [CW-1:0] count_q, count_d;
  logic [GW-1:0] gap_q, gap_d;
  logic [AW-1:0] idx_q, idx_d;
  logic          swapped_q, swapped_d;
  logic          signed_q;
  logic          strobe_q;
  logic          last_q;

  logic                      full;
  logic [CW:0]               pass_end;
  logic [CW:0]               pos_b;
  logic [AW-1:0]             addr_b;
  logic                      we;
  logic [AW-1:0]             waddr;
  logic [KEY_WIDTH-1:0]      wdata;
  logic [KEY_WIDTH-1:0]      rd_a;
  logic [KEY_WIDTH-1:0]      rd_b;
  logic [KEY_WIDTH-1:0]      sign_mask;
  logic [cs_pkg::KEY_WIDE_BITS-1:0] key_wide;
  logic [cs_pkg::KEY_WIDE_BITS-1:0] out_wide;

  // Pass bookkeeping
  assign full     = (count_q == CW'(MAX_KEYS));
  assign pass_end = (CW+1)'(idx_q) + (CW+1)'(gap_q) + (CW+1)'(2);
  assign pos_b    = (CW+1)'(idx_q) + (CW+1)'(gap_q) + (CW+1)'(1);
  assign addr_b   = pos_b[AW-1:0];

  // Compare with the sign bit flipped for signed keys
  always_comb begin
    sign_mask            = '0;
    sign_mask[KEY_WIDTH-1] = signed_q;
  end

  assign status_o.single    = (count_q < CW'(2));
  assign status_o.pass_last = (pass_end >= (CW+1)'(count_q));
  assign status_o.sort_done = (gap_q == '0) && !swapped_q;
  assign status_o.do_swap   = ((rd_a ^ sign_mask) > (rd_b ^ sign_mask));
  assign status_o.emit_last = ((CW'(idx_q) + CW'(1)) == count_q);

  // Working registers next values
  always_comb begin
    count_d   = count_q;
    gap_d     = gap_q;
    idx_d     = idx_q;
    swapped_d = swapped_q;
    if (cmd_i.clear) begin
      count_d   = '0;
      gap_d     = '0;
      idx_d     = '0;
      swapped_d = 1'b0;
    end
    if (cmd_i.load && !full) begin
      count_d = count_q + CW'(1);
    end
    if (cmd_i.sort_init) begin
      gap_d     = GW'(cs_pkg::shrink(cs_pkg::SHRINK_IN_BITS'(count_q) -
                                     cs_pkg::SHRINK_IN_BITS'(1)));
      idx_d     = '0;
      swapped_d = 1'b0;
    end
    if (cmd_i.wr_first) begin
      swapped_d = 1'b1;
    end
    if (cmd_i.step) begin
      if (status_o.pass_last) begin
        idx_d     = '0;
        swapped_d = 1'b0;
        if (gap_q != '0) begin
          gap_d = GW'(cs_pkg::shrink(cs_pkg::SHRINK_IN_BITS'(gap_q)));
        end
      end else begin
        idx_d = idx_q + AW'(1);
      end
    end
    if (cmd_i.emit_rd) begin
      idx_d = idx_q + AW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      gap_q     <= '0;
      idx_q     <= '0;
      swapped_q <= 1'b0;
      signed_q  <= 1'b0;
      strobe_q  <= 1'b0;
      last_q    <= 1'b0;
    end else begin
      count_q   <= count_d;
      gap_q     <= gap_d;
      idx_q     <= idx_d;
      swapped_q <= swapped_d;
      strobe_q  <= cmd_i.emit_rd;
      last_q    <= cmd_i.emit_rd && status_o.emit_last;
      if (cfg_we_i) begin
        signed_q <= cfg_data_i;
      end
    end
  end

  // Store write port: load, first or second half of a swap
  assign key_wide = cs_pkg::KEY_WIDE_BITS'(key_i);

  always_comb begin
    we    = 1'b0;
    waddr = count_q[AW-1:0];
    wdata = key_wide[KEY_WIDTH-1:0];
    if (cmd_i.load && !full) begin
      we = 1'b1;
    end else if (cmd_i.wr_first) begin
      we    = 1'b1;
      waddr = idx_q;
      wdata = rd_b;
    end else if (cmd_i.wr_second) begin
      we    = 1'b1;
      waddr = addr_b;
      wdata = rd_a;
    end
  end

  cs_ram #(
    .WIDTH(KEY_WIDTH),
    .DEPTH(MAX_KEYS)
  ) u_store (
    .clk_i    (clk_i),
    .we_i     (we),
    .waddr_i  (waddr),
    .wdata_i  (wdata),
    .re_a_i   (cmd_i.rd_pair || cmd_i.emit_rd),
    .raddr_a_i(idx_q),
    .re_b_i   (cmd_i.rd_pair),
    .raddr_b_i(addr_b),
    .rdata_a_o(rd_a),
    .rdata_b_o(rd_b)
  );

  // Result: store read data straight onto the ports
  assign out_wide         = cs_pkg::KEY_WIDE_BITS'(rd_a);
  assign res_o.sorted_key = out_wide[cs_pkg::KEY_BITS-1:0];
  assign res_o.end_of_set = last_q;
  assign res_strobe_o     = strobe_q;

endmodule

// ===== tb/comb_sorter_checker.sv =====
// Scoreboard for the comb sorter: watches the key, result and config channels,
// predicts the sorted output of each set and compares it with the block's output.
// Depends on cs_pkg for the key_in_t and key_out_t payload types.
`timescale 1ns / 1ps

module comb_sorter_checker (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  input  logic             busy,
  input  cs_pkg::key_in_t  key_i,
  input  cs_pkg::key_out_t res_o,
  input  logic             res_strobe_o,
  input  logic             cfg_valid_i,
  input  logic             cfg_ready_o,
  input  logic             cfg_data_i,
  output int               error_count_o,
  output int               pending_o,
  output int               keys_seen_o,
  output int               sets_seen_o,
  output int               results_checked_o
);

  localparam int STORE_DEPTH = 64;
  localparam int PRINT_CAP   = 40;

  // Shadow state of the sorter
  logic [31:0]      held_keys [STORE_DEPTH];
  int               held_count;
  logic             signed_mode;
  cs_pkg::key_out_t sorted_queue [$];

  // Print one mismatch line and count it
  task automatic report_mismatch(input string what);
    if (error_count_o < PRINT_CAP) begin
      $display("[%0t] comb_sorter mismatch: %s", $realtime, what);
    end
    error_count_o++;
  endtask

  // True when key a belongs after key b in the current compare mode
  function automatic logic key_after(input logic [31:0] a, input logic [31:0] b);
    if (signed_mode) begin
      return $signed(a) > $signed(b);
    end
    return a > b;
  endfunction

  // Comb sort of the held keys, gap shrinking by 10/13
  function automatic void comb_sort_held();
    int gap;
    int span;
    logic swapped;
    logic zero_pass_done;
    logic [31:0] tmp;
    if (held_count < 2) return;
    gap = ((held_count - 1) * 10) / 13;
    zero_pass_done = 1'b0;
    do begin
      span = gap + 1;
      swapped = 1'b0;
      for (int i = 0; i + span < held_count; i++) begin
        if (key_after(held_keys[i], held_keys[i + span])) begin
          tmp = held_keys[i];
          held_keys[i] = held_keys[i + span];
          held_keys[i + span] = tmp;
          swapped = 1'b1;
        end
      end
      if (gap == 0) zero_pass_done = 1'b1;
      else gap = (gap * 10) / 13;
    end while (!zero_pass_done || swapped);
  endfunction

  // Hold a key, and on the last key of a set queue the sorted set
  function automatic void accept_key(input cs_pkg::key_in_t item);
    cs_pkg::key_out_t exp_item;
    if (held_count < STORE_DEPTH) begin
      held_keys[held_count] = item.key;
      held_count++;
    end
    if (!item.is_last) return;
    comb_sort_held();
    for (int i = 0; i < held_count; i++) begin
      exp_item.sorted_key = held_keys[i];
      exp_item.end_of_set = (i == held_count - 1);
      sorted_queue.push_back(exp_item);
    end
    held_count = 0;
  endfunction

  // Track transfers on every channel and compare results
  always @(posedge clk_i or negedge rst_ni) begin
    cs_pkg::key_out_t exp_item;
    if (!rst_ni) begin
      held_count  = 0;
      signed_mode = 1'b0;
      sorted_queue.delete();
    end else begin
      if (cfg_valid_i === 1'b1 && cfg_ready_o === 1'b1) begin
        signed_mode = cfg_data_i;
      end
      if (start === 1'b1 && busy === 1'b0) begin
        keys_seen_o++;
        if (key_i.is_last) sets_seen_o++;
        accept_key(key_i);
      end
      if (res_strobe_o === 1'b1) begin
        if (sorted_queue.size() == 0) begin
          report_mismatch($sformatf("unexpected result key=%h end_of_set=%b",
                                    res_o.sorted_key, res_o.end_of_set));
        end else begin
          exp_item = sorted_queue.pop_front();
          results_checked_o++;
          if (res_o.sorted_key !== exp_item.sorted_key) begin
            report_mismatch($sformatf("sorted_key %h, expected %h",
                                      res_o.sorted_key, exp_item.sorted_key));
          end
          if (res_o.end_of_set !== exp_item.end_of_set) begin
            report_mismatch($sformatf("end_of_set %b, expected %b (key %h)",
                                      res_o.end_of_set, exp_item.end_of_set,
                                      exp_item.sorted_key));
          end
        end
      end
    end
    pending_o = sorted_queue.size();
  end

  initial begin
    error_count_o     = 0;
    pending_o         = 0;
    keys_seen_o       = 0;
    sets_seen_o       = 0;
    results_checked_o = 0;
    held_count        = 0;
    signed_mode       = 1'b0;
  end

endmodule

// ===== tb/tb_comb_sorter_top.sv =====
// Testbench top for comb_sorter_top: drives key sets and config writes, runs the
// watchdog and prints the verdict. Depends on cs_pkg and comb_sorter_checker.
`timescale 1ns / 1ps

module tb_comb_sorter_top;

  localparam int STALL_LIMIT = 20000;
  localparam int SEG_ITEMS   = 24;

  logic             clk_i;
  logic             rst_ni;
  logic             start;
  logic             busy;
  cs_pkg::key_in_t  key_in;
  cs_pkg::key_out_t sorted_out;
  logic             res_strobe;
  logic             cfg_valid;
  logic             cfg_ready;
  logic             cfg_data;

  int          error_count;
  int          pending;
  int          keys_seen;
  int          sets_seen;
  int          results_checked;
  int          idle_pct;
  int          stall_cycles;
  logic [31:0] prev_key;

  comb_sorter_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .key_i        (key_in),
    .res_o        (sorted_out),
    .res_strobe_o (res_strobe),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_data_i   (cfg_data)
  );

  comb_sorter_checker u_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .key_i             (key_in),
    .res_o             (sorted_out),
    .res_strobe_o      (res_strobe),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_o       (cfg_ready),
    .cfg_data_i        (cfg_data),
    .error_count_o     (error_count),
    .pending_o         (pending),
    .keys_seen_o       (keys_seen),
    .sets_seen_o       (sets_seen),
    .results_checked_o (results_checked)
  );

  // Free-running clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // End the run when no transfer happens for too long
  always @(posedge clk_i) begin
    if ((start && !busy) || res_strobe || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
        $display("tb_comb_sorter_top: errors");
        $finish;
      end
    end
  end

  // Offer one key, idling at random first; return at a falling edge with start low
  task automatic send_key(input logic [31:0] k, input logic last);
    while ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      @(negedge clk_i);
    end
    start = 1'b1;
    key_in.key = k;
    key_in.is_last = last;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    @(negedge clk_i);
    start = 1'b0;
  endtask

  // Wait until every sorted key has come out, then let the block settle
  task automatic drain();
    while (pending != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  // Write the compare mode while the block is idle
  task automatic write_mode(input logic mode);
    drain();
    cfg_valid = 1'b1;
    cfg_data = mode;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid = 1'b0;
    cfg_data = 1'($urandom_range(1));
  endtask

  // Mix of extremes, repeats, small values and full-range keys
  function automatic logic [31:0] pick_key();
    case ($urandom_range(9))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'h7FFF_FFFF;
      4: return prev_key;
      5: return $urandom_range(15);
      default: return $urandom;
    endcase
  endfunction

  // Send a set of random keys, last mark on the final one
  task automatic send_random_set(input int len);
    logic [31:0] k;
    for (int i = 0; i < len; i++) begin
      k = pick_key();
      prev_key = k;
      send_key(k, i == len - 1);
    end
  endtask

  initial begin
    int seg_count;
    int len;
    logic [31:0] mixed_set [7];
    rst_ni = 1'b0;
    start = 1'b0;
    key_in = '0;
    cfg_valid = 1'b0;
    cfg_data = 1'b0;
    stall_cycles = 0;
    idle_pct = 19;
    prev_key = 32'h0;
    mixed_set = '{32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0, 32'd5, 32'd5, 32'd1};
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: single keys at both extremes, unsigned compare from reset
    send_key(32'hFFFF_FFFF, 1'b1);
    send_key(32'h0000_0000, 1'b1);
    // Extremes and equal keys under both compare modes
    for (int i = 0; i < 7; i++) send_key(mixed_set[i], i == 6);
    write_mode(1'b1);
    for (int i = 0; i < 7; i++) send_key(mixed_set[i], i == 6);
    send_key(32'd1, 1'b0);
    send_key(32'h8000_0000, 1'b1);
    for (int i = 0; i < 3; i++) send_key(32'd9, i == 2);

    // Random segments: compare mode changes per segment, sender idle rate steps 19, 66, 0, 0
    for (int seg = 0; seg < 4; seg++) begin
      idle_pct = (seg == 0) ? 19 : (seg == 1) ? 66 : 0;
      write_mode(seg[0]);
      seg_count = 0;
      // Full store, then one key past it, open the middle segments
      if (seg == 1 || seg == 2) begin
        len = 63 + seg;
        send_random_set(len);
        seg_count += len;
      end
      while (seg_count < SEG_ITEMS) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        send_random_set(len);
        seg_count += len;
      end
    end

    drain();
    repeat (20) @(negedge clk_i);
    $display("Covered %0d keys in %0d sets, sets of 1 to 65 keys incl. store overflow;",
             keys_seen, sets_seen);
    $display("%0d sorted keys checked under unsigned and signed compare.", results_checked);
    if (error_count == 0 && pending == 0) begin
      $display("tb_comb_sorter_top: clean");
    end else begin
      $display("tb_comb_sorter_top: errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/cs_pkg.sv
src/cs_ram.sv
src/cs_ctrl.sv
src/cs_datapath.sv
src/comb_sorter_top.sv
tb/comb_sorter_checker.sv
tb/tb_comb_sorter_top.sv
